[src/ldm_pkg.sv]
// Shared types, character codes and helpers for the legacy symbol demangler.
`default_nettype none
package ldm_pkg;

    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_B      = 8'h42;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_T      = 8'h54;
    localparam logic [7:0] CH_L      = 8'h4C;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_F      = 8'h46;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [3:0] HEX_TEN   = 4'hA;

    localparam int          MAX_DEC  = 5;
    localparam logic [2:0]  SKIP_U   = 3'd4;

    typedef struct packed {
        logic load;     // request accepted, shift it into the window
        logic decode;   // decode the window head
        logic advance;  // current output beat taken
    } t_cmd;

    typedef struct packed {
        logic silent;      // decode yields nothing to send
        logic final_beat;  // current output beat is the last of the group
    } t_sts;

    // {valid, value} of one hex digit, either case
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, c[3:0]};
        else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, c[3:0] - 4'd1 + HEX_TEN};
        else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, c[3:0] - 4'd1 + HEX_TEN};
        return r;
    endfunction

endpackage
`default_nettype wire

[src/legacy_symbol_demangler.sv]
// Top level of the legacy symbol demangler.
// Usage:
//  Slave channel: one mangled character per request on i_s_tdata, i_s_tlast
//  on the final character of a symbol. Master channel: one demangled
//  character per request on o_m_tdata, o_m_tlast on the final one, o_m_tuser
//  set on a closing beat that carries no character (tdata is then zero).
//  The last HASH_DIGITS+3 characters (the hash marker and digits) are held
//  in a shift window and never sent; each request decodes the window head.
// Timing:
//  A request is taken in one cycle and decoded in the next; its results then
//  go out one per cycle while i_m_tready is high, zero to five of them. The
//  next request is taken only after the last result has been taken.
// Reset: synchronous, active low; clears the window fill, escape state and
//  controller. Window bytes need no reset.
// Stall: while i_m_tready is low the current result holds and no input
//  request is taken.
`default_nettype none
module legacy_symbol_demangler
    import ldm_pkg::*;
#(
    parameter int HASH_DIGITS = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_s_tvalid,
    output logic       o_s_tready,
    input  wire  [7:0] i_s_tdata,   // [7:0] in_byte
    input  wire        i_s_tlast,   // in_last
    output logic       o_m_tvalid,
    input  wire        i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tlast,   // out_last
    output logic       o_m_tuser    // [0] out_empty
);

    t_cmd cmd;
    t_sts sts;

    ldm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ldm_dpath #(
        .HASH_DIGITS (HASH_DIGITS)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_byte  (i_s_tdata),
        .i_last  (i_s_tlast),
        .o_sts   (sts),
        .o_byte  (o_m_tdata),
        .o_last  (o_m_tlast),
        .o_empty (o_m_tuser)
    );

endmodule
`default_nettype wire

[src/ldm_ctrl.sv]
// Controller state machine: input, decode and output phases.
`default_nettype none
module ldm_ctrl
    import ldm_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_s_tvalid,
    output logic o_s_tready,
    output logic o_m_tvalid,
    input  wire  i_m_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [1:0] S_IN  = 2'd0;
    localparam logic [1:0] S_DEC = 2'd1;
    localparam logic [1:0] S_OUT = 2'd2;

    logic [1:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IN:    if (i_s_tvalid) n_state = S_DEC;
            S_DEC:   n_state = i_sts.silent ? S_IN : S_OUT;
            S_OUT:   if (i_m_tready && i_sts.final_beat) n_state = S_IN;
            default: n_state = S_IN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IN;
        else          r_state <= n_state;
    end

    assign o_s_tready     = (r_state == S_IN);
    assign o_m_tvalid     = (r_state == S_OUT);
    assign o_cmd.load     = (r_state == S_IN) && i_s_tvalid;
    assign o_cmd.decode   = (r_state == S_DEC);
    assign o_cmd.advance  = (r_state == S_OUT) && i_m_tready;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid)) else $error("ready and valid together");
    a_dec_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.decode) else $error("decode did not follow load");
    a_dec_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.decode |=> !o_cmd.decode) else $error("decode lasted two cycles");

endmodule
`default_nettype wire

[src/ldm_dpath.sv]
// Datapath: byte window, escape decoder and output beat buffer.
`default_nettype none
module ldm_dpath
    import ldm_pkg::*;
#(
    parameter int HASH_DIGITS = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_cmd       i_cmd,
    input  wire  [7:0] i_byte,
    input  wire        i_last,
    output t_sts       o_sts,
    output logic [7:0] o_byte,
    output logic       o_last,
    output logic       o_empty
);

    localparam int DEPTH = HASH_DIGITS + 4;  // tail plus the head under decode
    localparam int FW    = $clog2(DEPTH + 1);

    logic [7:0]    r_win [DEPTH];
    logic [FW-1:0] r_fill;
    logic [2:0]    r_skip, n_skip;
    logic          r_first, n_first;
    logic          r_last;
    logic [7:0]    r_buf [MAX_DEC];
    logic [7:0]    n_buf [MAX_DEC];
    logic [2:0]    r_cnt, n_cnt;
    logic          r_empty;
    logic [2:0]    r_idx;

    logic          full;
    logic [7:0]    w0, w1, w2, w3, w4;
    logic [4:0]    hx_hi, hx_lo;
    logic          bracket4;

    assign full     = (r_fill == FW'(DEPTH));
    assign w0       = r_win[0];
    assign w1       = r_win[1];
    assign w2       = r_win[2];
    assign w3       = r_win[3];
    assign w4       = r_win[4];
    assign hx_hi    = hex_digit(w2);
    assign hx_lo    = hex_digit(w3);
    assign bracket4 = (w0 == CH_DOLLAR) && (w3 == CH_DOLLAR);

    always_comb begin
        n_skip  = r_skip;
        n_first = r_first;
        n_cnt   = 3'd0;
        for (int k = 0; k < MAX_DEC; k++) n_buf[k] = 8'd0;
        if (full) begin
            if (r_skip != 3'd0) begin
                n_skip = r_skip - 3'd1;
            end else if (r_first && w0 == CH_UNDER && w1 == CH_DOLLAR) begin
                n_first = 1'b0;
            end else begin
                n_first = 1'b0;
                n_cnt   = 3'd1;
                n_buf[0] = w0;
                if (w0 == CH_DOT && w1 == CH_DOT) begin
                    n_buf[0] = CH_COLON; n_buf[1] = CH_COLON;
                    n_cnt = 3'd2; n_skip = 3'd1;
                end else if (w0 == CH_DOLLAR && w1 == CH_C && w2 == CH_DOLLAR) begin
                    n_buf[0] = CH_COMMA; n_skip = 3'd2;
                end else if (bracket4 && w1 == CH_B && w2 == CH_P) begin
                    n_buf[0] = CH_STAR; n_skip = 3'd3;
                end else if (bracket4 && w1 == CH_G && w2 == CH_T) begin
                    n_buf[0] = CH_GT; n_skip = 3'd3;
                end else if (bracket4 && w1 == CH_L && w2 == CH_T) begin
                    n_buf[0] = CH_LT; n_skip = 3'd3;
                end else if (bracket4 && w1 == CH_L && w2 == CH_P) begin
                    n_buf[0] = CH_LPAREN; n_skip = 3'd3;
                end else if (bracket4 && w1 == CH_R && w2 == CH_P) begin
                    n_buf[0] = CH_RPAREN; n_skip = 3'd3;
                end else if (bracket4 && w1 == CH_R && w2 == CH_F) begin
                    n_buf[0] = CH_AMP; n_skip = 3'd3;
                end else if (bracket4 && w1 == CH_S && w2 == CH_P) begin
                    n_buf[0] = CH_AT; n_skip = 3'd3;
                end else if (w0 == CH_DOT) begin
                    n_buf[0] = CH_DASH;
                end else if (w0 == CH_DOLLAR && w1 == CH_U && w4 == CH_DOLLAR) begin
                    n_skip = SKIP_U;
                    if (hx_hi[4] && hx_lo[4]) begin
                        n_buf[0] = {hx_hi[3:0], hx_lo[3:0]};
                    end else begin
                        n_buf[1] = w1; n_buf[2] = w2; n_buf[3] = w3; n_buf[4] = w4;
                        n_cnt = 3'd5;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int k = 0; k < DEPTH - 1; k++) r_win[k] <= r_win[k+1];
            r_win[DEPTH-1] <= i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decode) begin
            for (int k = 0; k < MAX_DEC; k++) r_buf[k] <= n_buf[k];
            r_empty <= r_last && (n_cnt == 3'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_skip  <= 3'd0;
            r_first <= 1'b1;
            r_last  <= 1'b0;
            r_cnt   <= 3'd0;
            r_idx   <= 3'd0;
        end else begin
            if (i_cmd.load) begin
                r_last <= i_last;
                if (!full) r_fill <= r_fill + FW'(1);
            end
            if (i_cmd.decode) begin
                r_idx <= 3'd0;
                if (r_last) begin
                    r_cnt   <= (n_cnt == 3'd0) ? 3'd1 : n_cnt;
                    r_fill  <= '0;
                    r_skip  <= 3'd0;
                    r_first <= 1'b1;
                end else begin
                    r_cnt   <= n_cnt;
                    r_skip  <= n_skip;
                    r_first <= n_first;
                end
            end
            if (i_cmd.advance) r_idx <= r_idx + 3'd1;
        end
    end

    assign o_sts.silent     = (n_cnt == 3'd0) && !r_last;
    assign o_sts.final_beat = (r_idx == r_cnt - 3'd1);
    assign o_byte  = r_empty ? 8'd0 : r_buf[r_idx];
    assign o_last  = r_last && o_sts.final_beat;
    assign o_empty = r_empty;

    a_fill_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(DEPTH)) else $error("window overfilled");
    a_skip_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skip <= SKIP_U) else $error("skip count out of range");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.advance |-> (r_idx < r_cnt)) else $error("beat index past count");

endmodule
`default_nettype wire
